[src/nvmm_pkg.sv]
package nvmm_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int VALUE_W         = 31;
    localparam int COST_W          = 63;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic               item_kind;
        logic [VALUE_W-1:0] item_value;
    } item_t;

    typedef struct packed {
        logic               matched;
        logic [VALUE_W-1:0] partner_value;
        logic [VALUE_W-1:0] distance;
        logic [COST_W-1:0]  total_cost;
        logic               store_full_drop;
    } result_t;

    // outcome of one item as handed from the sequencer to the cost stage
    typedef struct packed {
        logic               matched;
        logic [VALUE_W-1:0] partner;
        logic [VALUE_W-1:0] delta;
        logic               drop;
    } match_t;

endpackage

[src/nvmm_store.sv]
module nvmm_store
    import nvmm_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic [AW-1:0]      raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [STORE_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/nvmm_ctrl.sv]
module nvmm_ctrl
    import nvmm_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  item_t              item,
    output logic               busy,
    output logic               fin,
    output match_t             res
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SRCH_RD  = 4'd1;
    localparam logic [3:0] ST_SRCH_CMP = 4'd2;
    localparam logic [3:0] ST_PRED_RD  = 4'd3;
    localparam logic [3:0] ST_PRED_CAP = 4'd4;
    localparam logic [3:0] ST_SUCC_RD  = 4'd5;
    localparam logic [3:0] ST_SUCC_CAP = 4'd6;
    localparam logic [3:0] ST_PICK     = 4'd7;
    localparam logic [3:0] ST_UP_RD    = 4'd8;
    localparam logic [3:0] ST_UP_WR    = 4'd9;
    localparam logic [3:0] ST_INS_WR   = 4'd10;
    localparam logic [3:0] ST_DN_RD    = 4'd11;
    localparam logic [3:0] ST_DN_WR    = 4'd12;
    localparam logic [3:0] ST_FIN      = 4'd13;

    logic [3:0]         state_reg,   state_next;
    logic [CW-1:0]      occ_reg,     occ_next;
    logic               wkind_reg,   wkind_next;
    logic               is_match_reg, is_match_next;
    logic [VALUE_W-1:0] v_reg,       v_next;
    logic [CW-1:0]      lo_reg,      lo_next;
    logic [CW-1:0]      hi_reg,      hi_next;
    logic [CW-1:0]      idx_reg,     idx_next;
    logic [VALUE_W-1:0] pred_reg,    pred_next;
    logic [VALUE_W-1:0] succ_reg,    succ_next;
    logic [VALUE_W-1:0] dp_reg,      dp_next;
    logic [VALUE_W-1:0] ds_reg,      ds_next;
    logic               matched_reg, matched_next;
    logic [VALUE_W-1:0] partner_reg, partner_next;
    logic [VALUE_W-1:0] dist_reg,    dist_next;
    logic               drop_reg,    drop_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      lo_m1;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      idx_p1;

    // the one shared subtractor: search compare, both distances, tie decision
    logic [VALUE_W-1:0] sub_a;
    logic [VALUE_W-1:0] sub_b;
    logic [VALUE_W:0]   sub_diff;
    logic               sub_borrow;

    logic               has_pred;
    logic               has_succ;

    nvmm_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign lo_m1   = lo_reg - 1'b1;
    assign idx_m1  = idx_reg - 1'b1;
    assign idx_p1  = idx_reg + 1'b1;

    assign has_pred = (lo_reg != '0);
    assign has_succ = (lo_reg != occ_reg);

    always_comb
    begin
        case (state_reg)
            ST_SRCH_CMP:
            begin
                sub_a = v_reg;
                sub_b = mem_rdata;
            end
            ST_SUCC_CAP:
            begin
                sub_a = mem_rdata;
                sub_b = v_reg;
            end
            // no borrow means dp <= ds
            ST_PICK:
            begin
                sub_a = ds_reg;
                sub_b = dp_reg;
            end
            default:
            begin
                sub_a = v_reg;
                sub_b = mem_rdata;
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[VALUE_W];

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        wkind_next    = wkind_reg;
        is_match_next = is_match_reg;
        v_next        = v_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        idx_next      = idx_reg;
        pred_next     = pred_reg;
        succ_next     = succ_reg;
        dp_next       = dp_reg;
        ds_next       = ds_reg;
        matched_next  = matched_reg;
        partner_next  = partner_reg;
        dist_next     = dist_reg;
        drop_next     = drop_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[AW-1:0];
        mem_wdata     = mem_rdata;
        mem_raddr     = mid[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    v_next       = item.item_value;
                    matched_next = 1'b0;
                    partner_next = '0;
                    dist_next    = '0;
                    drop_next    = 1'b0;
                    lo_next      = '0;
                    hi_next      = occ_reg;
                    if (occ_reg == '0)
                    begin
                        wkind_next = item.item_kind;
                        state_next = ST_INS_WR;
                    end
                    else if (item.item_kind == wkind_reg)
                    begin
                        is_match_next = 1'b0;
                        if (occ_reg == FULL_COUNT)
                        begin
                            drop_next  = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_SRCH_RD;
                        end
                    end
                    else
                    begin
                        is_match_next = 1'b1;
                        state_next    = ST_SRCH_RD;
                    end
                end
            end

            // upper bound: first entry greater than the item value
            ST_SRCH_RD:
            begin
                mem_raddr = mid[AW-1:0];
                if (lo_reg == hi_reg)
                begin
                    if (is_match_reg)
                    begin
                        state_next = has_pred ? ST_PRED_RD : ST_SUCC_RD;
                    end
                    else
                    begin
                        idx_next   = occ_reg;
                        state_next = ST_UP_RD;
                    end
                end
                else
                begin
                    state_next = ST_SRCH_CMP;
                end
            end

            ST_SRCH_CMP:
            begin
                if (!sub_borrow)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_SRCH_RD;
            end

            ST_PRED_RD:
            begin
                mem_raddr  = lo_m1[AW-1:0];
                state_next = ST_PRED_CAP;
            end

            ST_PRED_CAP:
            begin
                pred_next  = mem_rdata;
                dp_next    = sub_diff[VALUE_W-1:0];
                state_next = has_succ ? ST_SUCC_RD : ST_PICK;
            end

            ST_SUCC_RD:
            begin
                mem_raddr  = lo_reg[AW-1:0];
                state_next = ST_SUCC_CAP;
            end

            ST_SUCC_CAP:
            begin
                succ_next  = mem_rdata;
                ds_next    = sub_diff[VALUE_W-1:0];
                state_next = ST_PICK;
            end

            // ties go to the smaller neighbor
            ST_PICK:
            begin
                matched_next = 1'b1;
                if (has_pred && (!has_succ || !sub_borrow))
                begin
                    partner_next = pred_reg;
                    dist_next    = dp_reg;
                    idx_next     = lo_m1;
                end
                else
                begin
                    partner_next = succ_reg;
                    dist_next    = ds_reg;
                    idx_next     = lo_reg;
                end
                state_next = ST_DN_RD;
            end

            // close the gap, moving each higher entry down one slot
            ST_DN_RD:
            begin
                mem_raddr = idx_p1[AW-1:0];
                if (idx_p1 == occ_reg)
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_DN_WR;
                end
            end

            ST_DN_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_p1;
                state_next = ST_DN_RD;
            end

            // open a slot at the insert position, top entry first
            ST_UP_RD:
            begin
                mem_raddr = idx_m1[AW-1:0];
                if (idx_reg == lo_reg)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    state_next = ST_UP_WR;
                end
            end

            ST_UP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_m1;
                state_next = ST_UP_RD;
            end

            ST_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[AW-1:0];
                mem_wdata  = v_reg;
                occ_next   = occ_reg + 1'b1;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            wkind_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            wkind_reg <= wkind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_match_reg <= is_match_next;
        v_reg        <= v_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        pred_reg     <= pred_next;
        succ_reg     <= succ_next;
        dp_reg       <= dp_next;
        ds_reg       <= ds_next;
        matched_reg  <= matched_next;
        partner_reg  <= partner_next;
        dist_reg     <= dist_next;
        drop_reg     <= drop_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign fin         = (state_reg == ST_FIN);
    assign res.matched = matched_reg;
    assign res.partner = partner_reg;
    assign res.delta   = dist_reg;
    assign res.drop    = drop_reg;

endmodule

[src/nearest_value_multiset_matcher_core.sv]
// Nearest-value matcher over a sorted store of waiting values of one kind. A beat is taken
// when start is high and busy is low; busy then stays high until the item is finished. Items
// of the waiting kind are inserted in order, items of the other kind remove and report the
// nearest stored value (ties to the smaller one) and add the distance to a saturating total.
// Every item gives exactly one result, shown on result for the single cycle in which done is
// high, the first cycle with busy low again; the receiver cannot stall it, so it must be
// taken then. All store traffic runs through one memory with one read and one write port, so
// an item keeps busy high through a binary search over the stored values, a shift of one
// entry at a time to open or close a slot, and the insert write or, for a match, the neighbor
// reads, pick and bookkeeping; an insert into an empty store skips the search and the shift,
// and a dropped insert goes straight to its finish state without touching the store.
module nearest_value_multiset_matcher_core
    import nvmm_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic              fin;
    match_t            res;

    logic [COST_W-1:0] cost_reg, cost_next;
    logic [COST_W:0]   cost_sum;
    logic              done_reg;
    result_t           result_reg;

    nvmm_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .fin   (fin),
        .res   (res)
    );

    assign cost_sum = {1'b0, cost_reg} + {{(COST_W + 1 - VALUE_W){1'b0}}, res.delta};

    // carry out of the low bits means the total went past its maximum
    always_comb
    begin
        cost_next = cost_reg;
        if (fin && res.matched)
        begin
            cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cost_reg <= cost_next;
            done_reg <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            result_reg.matched         <= res.matched;
            result_reg.partner_value   <= res.partner;
            result_reg.distance        <= res.delta;
            result_reg.total_cost      <= cost_next;
            result_reg.store_full_drop <= res.drop;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    // the sequencer returns to idle between items, so result beats are never back to back
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats back to back");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat before sequencer went idle");

    a_drop_not_match: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.matched |-> result.partner_value == '0 && result.distance == '0)
        else $error("unmatched beat carries a partner or distance");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.matched && result.store_full_drop))
        else $error("beat both matched and dropped");
`endif

endmodule
